[hw/rtl/brse_pkg.sv]
// Shared types, constants and the ASCII to ITA2 lookup table for the Baudot RTTY encoder.
// Has no dependencies; every other file in this block imports it.
package brse_pkg;

    localparam int HOLD_W   = 20;
    localparam int CODE_W   = 5;
    localparam int CHAR_W   = 7;
    localparam int POS_W    = 3;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    localparam logic REG_BIT_PERIOD = 1'b0;
    localparam logic REG_SHIFT_GAP  = 1'b1;

    localparam logic FUNC_ASCII = 1'b0;
    localparam logic FUNC_RAW   = 1'b1;

    localparam logic LEVEL_SPACE = 1'b0;
    localparam logic LEVEL_MARK  = 1'b1;

    localparam logic [CODE_W-1:0] CODE_LTRS = 5'h1F;
    localparam logic [CODE_W-1:0] CODE_FIGS = 5'h1B;

    localparam logic [POS_W-1:0] POS_START = 3'd0;
    localparam logic [POS_W-1:0] POS_STOP  = 3'd6;

    localparam logic [HOLD_W-1:0] BIT_PERIOD_RESET = 20'd22000;
    localparam logic [HOLD_W-1:0] SHIFT_GAP_RESET  = 20'd0;

    typedef struct packed {
        logic              level;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } sym_t;

    // Bits 4..0 are the Baudot code, bit 5 is the figures flag.
    localparam logic [5:0] ITA2_ROM [0:127] = '{
        6'h00, 6'h00, 6'h00, 6'h00, 6'h34, 6'h00, 6'h00, 6'h2B, 6'h00, 6'h04,
        6'h02, 6'h00, 6'h02, 6'h08, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h04, 6'h2D, 6'h25, 6'h00, 6'h29, 6'h00, 6'h3A, 6'h25,
        6'h2F, 6'h32, 6'h00, 6'h00, 6'h2C, 6'h23, 6'h3C, 6'h3D, 6'h36, 6'h37,
        6'h33, 6'h21, 6'h2A, 6'h30, 6'h35, 6'h27, 6'h26, 6'h38, 6'h2E, 6'h3E,
        6'h00, 6'h00, 6'h00, 6'h39, 6'h00, 6'h03, 6'h19, 6'h0E, 6'h09, 6'h01,
        6'h0D, 6'h1A, 6'h14, 6'h06, 6'h0B, 6'h0F, 6'h12, 6'h1C, 6'h0C, 6'h18,
        6'h16, 6'h17, 6'h0A, 6'h05, 6'h10, 6'h07, 6'h1E, 6'h13, 6'h1D, 6'h15,
        6'h11, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h03, 6'h19, 6'h0E,
        6'h09, 6'h01, 6'h0D, 6'h1A, 6'h14, 6'h06, 6'h0B, 6'h0F, 6'h12, 6'h1C,
        6'h0C, 6'h18, 6'h16, 6'h17, 6'h0A, 6'h05, 6'h10, 6'h07, 6'h1E, 6'h13,
        6'h1D, 6'h15, 6'h11, 6'h00, 6'h00, 6'h00, 6'h00, 6'h1F
    };

endpackage

[hw/rtl/brse_seq.sv]
// Request register and symbol sequencer: looks up the character, decides on a shift frame
// and steps through the symbols of one or two frames. Depends on brse_pkg.
module brse_seq
    import brse_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_func,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_force,
    input  logic              adv,
    input  logic [HOLD_W-1:0] bit_period,
    input  logic [HOLD_W-1:0] shift_gap,
    output logic              sym_valid,
    output sym_t              sym
);

    logic              busy_reg, busy_next;
    logic              shift_reg, shift_next;
    logic              has_shift_reg, has_shift_next;
    logic              figs_reg, figs_next;
    logic              second_reg, second_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CODE_W-1:0] code_reg, code_next;

    logic [5:0]        entry;
    logic              accept;
    logic              step;
    logic              final_sym;
    logic              shift_frame;
    logic [CODE_W-1:0] frame_code;
    logic [POS_W-1:0]  bit_idx;

    assign entry       = ITA2_ROM[in_char];
    assign shift_frame = has_shift_reg && !second_reg;
    assign final_sym   = (pos_reg == POS_STOP) && !shift_frame;
    assign step        = busy_reg && adv;
    assign in_ready    = !busy_reg || (adv && final_sym);
    assign accept      = in_valid && in_ready;
    assign sym_valid   = busy_reg;
    assign frame_code  = shift_frame ? (figs_reg ? CODE_FIGS : CODE_LTRS) : code_reg;
    assign bit_idx     = pos_reg - 3'd1;

    always_comb begin
        sym.level   = LEVEL_SPACE;
        sym.hold_us = bit_period;
        sym.last    = 1'b0;
        case (pos_reg)
            POS_START: begin
                sym.level = LEVEL_SPACE;
            end
            POS_STOP: begin
                sym.level   = LEVEL_MARK;
                sym.hold_us = shift_frame ? shift_gap : '0;
                sym.last    = !shift_frame;
            end
            default: begin
                sym.level = frame_code[bit_idx];
            end
        endcase
    end

    always_comb begin
        busy_next      = busy_reg;
        shift_next     = shift_reg;
        has_shift_next = has_shift_reg;
        figs_next      = figs_reg;
        second_next    = second_reg;
        pos_next       = pos_reg;
        code_next      = code_reg;
        if (accept) begin
            busy_next   = 1'b1;
            pos_next    = POS_START;
            second_next = 1'b0;
            figs_next   = entry[5];
            if (in_func == FUNC_RAW) begin
                has_shift_next = 1'b0;
                code_next      = in_char[CODE_W-1:0];
            end else begin
                has_shift_next = (entry[5] != shift_reg) || in_force;
                code_next      = entry[CODE_W-1:0];
                shift_next     = entry[5];
            end
        end else if (step) begin
            if (final_sym) begin
                busy_next = 1'b0;
            end else if (pos_reg == POS_STOP) begin
                pos_next    = POS_START;
                second_next = 1'b1;
            end else begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            shift_reg     <= 1'b0;
            has_shift_reg <= 1'b0;
            second_reg    <= 1'b0;
            pos_reg       <= POS_START;
        end else begin
            busy_reg      <= busy_next;
            shift_reg     <= shift_next;
            has_shift_reg <= has_shift_next;
            second_reg    <= second_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        figs_reg <= figs_next;
        code_reg <= code_next;
    end

    a_idle_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && final_sym && !in_valid) |=> !busy_reg)
        else $error("sequencer stayed busy after the final symbol");

    a_second_needs_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && second_reg) |-> has_shift_reg)
        else $error("second frame without a shift frame");

    a_shift_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(shift_reg))
        else $error("shift state changed without a new request");

    a_no_accept_mid_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !final_sym) |-> !in_ready)
        else $error("request taken while symbols remain");

endmodule

[hw/rtl/brse_out.sv]
// Output register for the symbol stream; the sequencer steps only while this register is
// empty or its symbol is being taken. Depends on brse_pkg.
module brse_out
    import brse_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                sym_valid,
    input  sym_t                sym,
    output logic                adv,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic valid_reg;
    sym_t sym_reg;

    assign adv      = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_W - HOLD_W - 1){1'b0}}, sym_reg.hold_us, sym_reg.level};
    assign m_tlast  = sym_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= sym_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sym_reg <= sym;
        end
    end

endmodule

[hw/rtl/baudot_rtty_symbol_encoder_top.sv]
// Baudot RTTY symbol encoder, top level. A request's first symbol passes the sequencer
// registers and then the output register to m_. One symbol per cycle while the output
// register is empty or taken, set by the symbol counter: 7 symbols per request, or 14
// when a shift frame goes first. The next request is taken in the cycle the final symbol
// leaves the sequencer. Reset clears the shift to letters, the bit period to 22000 us and the shift gap to 0.
module baudot_rtty_symbol_encoder_top
    import brse_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // char_code[6:0], force_shift[7]
    input  logic                s_tuser,   // func[0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // level[0], hold_us[20:1], zero[23:21]
    output logic                m_tlast,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [HOLD_W-1:0]   cfg_data
);

    logic [HOLD_W-1:0] bit_period_reg;
    logic [HOLD_W-1:0] shift_gap_reg;
    logic              adv;
    logic              sym_valid;
    sym_t              sym;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg <= BIT_PERIOD_RESET;
            shift_gap_reg  <= SHIFT_GAP_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BIT_PERIOD: bit_period_reg <= cfg_data;
                REG_SHIFT_GAP:  shift_gap_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    brse_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_char    (s_tdata[CHAR_W-1:0]),
        .in_force   (s_tdata[CHAR_W]),
        .adv        (adv),
        .bit_period (bit_period_reg),
        .shift_gap  (shift_gap_reg),
        .sym_valid  (sym_valid),
        .sym        (sym)
    );

    brse_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sym_valid (sym_valid),
        .sym       (sym),
        .adv       (adv),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[bench/baudot_rtty_symbol_encoder_top_test.sv]
// Self-checking bench for the Baudot RTTY symbol encoder: drives characters and raw codes,
// predicts every frame symbol in a scoreboard and compares each symbol on the result stream.
// Depends on brse_pkg and baudot_rtty_symbol_encoder_top.
module baudot_rtty_symbol_encoder_top_test;
    import brse_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int FRAME_SYMS     = 7;

    // Bits 4..0 Baudot code, bit 5 figures flag, bit 6 not used.
    localparam bit [6:0] ASCII_TO_ITA2 [0:127] = '{
        7'h40, 7'h40, 7'h40, 7'h40, 7'h34, 7'h40, 7'h40, 7'h2B, 7'h40, 7'h44,
        7'h42, 7'h40, 7'h42, 7'h48, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40,
        7'h40, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40,
        7'h40, 7'h40, 7'h44, 7'h2D, 7'h25, 7'h40, 7'h29, 7'h40, 7'h3A, 7'h25,
        7'h2F, 7'h32, 7'h40, 7'h40, 7'h2C, 7'h23, 7'h3C, 7'h3D, 7'h36, 7'h37,
        7'h33, 7'h21, 7'h2A, 7'h30, 7'h35, 7'h27, 7'h26, 7'h38, 7'h2E, 7'h3E,
        7'h40, 7'h40, 7'h40, 7'h39, 7'h40, 7'h03, 7'h19, 7'h0E, 7'h09, 7'h01,
        7'h0D, 7'h1A, 7'h14, 7'h06, 7'h0B, 7'h0F, 7'h12, 7'h1C, 7'h0C, 7'h18,
        7'h16, 7'h17, 7'h0A, 7'h05, 7'h10, 7'h07, 7'h1E, 7'h13, 7'h1D, 7'h15,
        7'h11, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40, 7'h03, 7'h19, 7'h0E,
        7'h09, 7'h01, 7'h0D, 7'h1A, 7'h14, 7'h06, 7'h0B, 7'h0F, 7'h12, 7'h1C,
        7'h0C, 7'h18, 7'h16, 7'h17, 7'h0A, 7'h05, 7'h10, 7'h07, 7'h1E, 7'h13,
        7'h1D, 7'h15, 7'h11, 7'h40, 7'h40, 7'h40, 7'h40, 7'h5F
    };

    class rtty_frame_scoreboard;
        bit [HOLD_W-1:0] bit_period = BIT_PERIOD_RESET;
        bit [HOLD_W-1:0] shift_gap  = SHIFT_GAP_RESET;
        bit              figs_shift = 1'b0;
        sym_t            frame_syms [$];
        int              errors     = 0;

        function void push_frame(bit [CODE_W-1:0] code, bit [HOLD_W-1:0] stop_hold, bit fin);
            sym_t s;
            s = '{level: LEVEL_SPACE, hold_us: bit_period, last: 1'b0};
            frame_syms.push_back(s);
            for (int i = 0; i < CODE_W; i++) begin
                s = '{level: code[i], hold_us: bit_period, last: 1'b0};
                frame_syms.push_back(s);
            end
            s = '{level: LEVEL_MARK, hold_us: stop_hold, last: fin};
            frame_syms.push_back(s);
        endfunction

        function void note_request(bit func, bit [CHAR_W-1:0] ch, bit force_sh);
            bit [6:0] entry;
            entry = ASCII_TO_ITA2[ch];
            if (func == FUNC_RAW) begin
                push_frame(ch[CODE_W-1:0], '0, 1'b1);
            end else begin
                if (entry[5] != figs_shift || force_sh) begin
                    push_frame(entry[5] ? CODE_FIGS : CODE_LTRS, shift_gap, 1'b0);
                    figs_shift = entry[5];
                end
                push_frame(entry[CODE_W-1:0], '0, 1'b1);
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_symbol(bit level, bit [HOLD_W-1:0] hold_us, bit last);
            sym_t exp_sym;
            if (frame_syms.size() == 0) begin
                report($sformatf("unexpected symbol level=%0b hold=%0d last=%0b",
                                 level, hold_us, last));
            end else begin
                exp_sym = frame_syms.pop_front();
                if (level != exp_sym.level)
                    report($sformatf("level %0b, expected %0b", level, exp_sym.level));
                if (hold_us != exp_sym.hold_us)
                    report($sformatf("hold_us %0d, expected %0d", hold_us, exp_sym.hold_us));
                if (last != exp_sym.last)
                    report($sformatf("last %0b, expected %0b", last, exp_sym.last));
            end
        endtask

        function int pending();
            return frame_syms.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tuser   = FUNC_ASCII;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_we    = 1'b0;
    logic                cfg_addr  = REG_BIT_PERIOD;
    logic [HOLD_W-1:0]   cfg_data  = '0;

    rtty_frame_scoreboard sb;
    bit quiet = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;

    baudot_rtty_symbol_encoder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_symbol(m_tdata[0], m_tdata[HOLD_W:1], m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task send_request(bit func, bit [CHAR_W-1:0] ch, bit force_sh);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {force_sh, ch};
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(func, ch, force_sh);
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task set_timing(bit [HOLD_W-1:0] bit_period, bit [HOLD_W-1:0] shift_gap);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_BIT_PERIOD;
        cfg_data <= bit_period;
        @(posedge aclk);
        cfg_addr <= REG_SHIFT_GAP;
        cfg_data <= shift_gap;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.bit_period = bit_period;
        sb.shift_gap  = shift_gap;
        @(posedge aclk);
    endtask

    task random_burst(int count);
        bit [CHAR_W-1:0] ch;
        bit              func;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            func = ($urandom_range(0, 99) < 15) ? FUNC_RAW : FUNC_ASCII;
            ch = ($urandom_range(0, 99) < 60) ? CHAR_W'($urandom_range(32, 95))
                                               : CHAR_W'($urandom_range(0, 127));
            send_request(func, ch, $urandom_range(0, 9) == 0);
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    initial begin
        sb = new;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Letters, figures, forced shifts, unmapped characters and raw codes.
        send_request(FUNC_ASCII, 7'h41, 1'b0);
        send_request(FUNC_ASCII, 7'h31, 1'b0);
        send_request(FUNC_ASCII, 7'h32, 1'b0);
        send_request(FUNC_RAW,   7'h7F, 1'b1);
        send_request(FUNC_ASCII, 7'h3F, 1'b0);
        send_request(FUNC_ASCII, 7'h42, 1'b0);
        send_request(FUNC_ASCII, 7'h43, 1'b1);
        send_request(FUNC_ASCII, 7'h00, 1'b0);
        send_request(FUNC_ASCII, 7'h33, 1'b0);
        send_request(FUNC_ASCII, 7'h00, 1'b0);
        send_request(FUNC_ASCII, 7'h7F, 1'b0);
        send_request(FUNC_RAW,   7'h00, 1'b0);
        send_request(FUNC_RAW,   7'h1F, 1'b0);
        send_request(FUNC_RAW,   7'h60, 1'b0);
        send_request(FUNC_ASCII, 7'h04, 1'b0);
        send_request(FUNC_ASCII, 7'h07, 1'b1);
        send_request(FUNC_ASCII, 7'h09, 1'b0);
        send_request(FUNC_ASCII, 7'h0D, 1'b0);
        send_request(FUNC_ASCII, 7'h7A, 1'b0);
        send_request(FUNC_ASCII, 7'h20, 1'b0);
        send_request(FUNC_ASCII, 7'h21, 1'b0);
        send_request(FUNC_RAW,   7'h55, 1'b1);
        send_request(FUNC_ASCII, 7'h7E, 1'b0);
        wait_drained();

        random_burst(60);
        set_timing(20'd1, 20'd0);
        random_burst(80);
        set_timing(20'd0, 20'hFFFFF);
        random_burst(80);
        set_timing(20'hFFFFF, 20'd1);
        random_burst(80);
        set_timing(20'd1000000, 20'd1000000);
        random_burst(70);
        set_timing(HOLD_W'($urandom_range(1, 1000000)), HOLD_W'($urandom_range(0, 1000000)));
        random_burst(80);

        repeat (16) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/brse_pkg.sv
hw/rtl/brse_seq.sv
hw/rtl/brse_out.sv
hw/rtl/baudot_rtty_symbol_encoder_top.sv
bench/baudot_rtty_symbol_encoder_top_test.sv
